// ===== src/pre_pkg.sv =====
// Package: shared types and constants for the page record extractor.
`default_nettype none
package pre_pkg;

  localparam int unsigned PAGE_BYTES  = 4096;
  localparam int unsigned DATA_BYTES  = PAGE_BYTES - 2;
  localparam int unsigned HDR_BYTES   = 5;
  localparam int unsigned DELETED_BIT = 0;
  localparam int unsigned OFFS_W      = 12;

  typedef logic [OFFS_W-1:0] offs_t;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_USED_HI,
    PH_FLAG,
    PH_LEN,
    PH_PAYLOAD,
    PH_DONE
  } phase_e;

  typedef struct packed {
    logic        valid;
    logic [31:0] out_page;
    offs_t       row_offset;
    offs_t       row_length;
    logic [7:0]  payload_byte;
    logic        last_of_row;
    logic        empty_row;
  } pre_result_t;

endpackage
`default_nettype wire

// ===== src/pre_if.sv =====
// Interfaces: input byte channel and record result channel.
`default_nettype none
interface pre_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_of_page;
  logic [31:0] page_number;

  modport source (output valid, output data_byte, output first_of_page,
                  output page_number, input ready);
  modport sink   (input valid, input data_byte, input first_of_page,
                  input page_number, output ready);
endinterface

interface pre_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_page;
  logic [11:0] row_offset;
  logic [11:0] row_length;
  logic [7:0]  payload_byte;
  logic        last_of_row;
  logic        empty_row;

  modport source (output valid, output out_page, output row_offset, output row_length,
                  output payload_byte, output last_of_row, output empty_row,
                  input ready);
  modport sink   (input valid, input out_page, input row_offset, input row_length,
                  input payload_byte, input last_of_row, input empty_row,
                  output ready);
endinterface
`default_nettype wire

// ===== src/page_record_extractor.sv =====
// Top level: record extractor for streamed data pages, with a registered result stage.
//
// Input channel in_i carries one page byte per beat, with its page number and a
// first-of-page mark. The first two bytes of a page give the used count; the
// records after them (flag, 4-byte length, payload) are walked in order.
// Output channel out_o gives one beat per payload byte of every live record that fits
// the used count, or a single empty-row beat for such a record of zero length.
// Throughput: one input byte per cycle while the receiver does not stall out_o.
// A result is registered and appears on out_o in the cycle after the byte that causes it.
// The result register takes a new beat while its current one is being taken,
// so in_i.ready is low only while out_o holds a beat the receiver has not taken.
// A stalled receiver holds the result beat stable and backs up the input.
// Reset clears the parser to wait for a page start; bytes before the first
// first-of-page mark are dropped, and no result is pending after reset.
`default_nettype none
module page_record_extractor (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pre_in_if.sink    in_i,
  pre_out_if.source out_o
);
  import pre_pkg::*;

  pre_result_t res;
  logic        beat;
  logic        out_valid_q, out_valid_d;
  pre_result_t out_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign beat       = in_i.valid && in_i.ready;

  pre_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .beat_i         (beat),
    .data_byte_i    (in_i.data_byte),
    .first_of_page_i(in_i.first_of_page),
    .page_number_i  (in_i.page_number),
    .result_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    if (beat && res.valid) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat && res.valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_page     = out_q.out_page;
  assign out_o.row_offset   = out_q.row_offset;
  assign out_o.row_length   = out_q.row_length;
  assign out_o.payload_byte = out_q.payload_byte;
  assign out_o.last_of_row  = out_q.last_of_row;
  assign out_o.empty_row    = out_q.empty_row;

endmodule
`default_nettype wire

// ===== src/pre_parser.sv =====
// Page parser: per-byte state machine that walks the record headers and payloads.
`default_nettype none
module pre_parser (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                beat_i,
  input  wire logic [7:0]          data_byte_i,
  input  wire logic                first_of_page_i,
  input  wire logic [31:0]         page_number_i,
  output pre_pkg::pre_result_t     result_o
);
  import pre_pkg::*;

  phase_e      phase_q, phase_d;
  offs_t       used_q, used_d;
  offs_t       pos_q, pos_d;
  offs_t       start_q, start_d;
  logic        del_q, del_d;
  logic [23:0] acc_q, acc_d;
  offs_t       len_q, len_d;
  offs_t       rem_q, rem_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [31:0] page_q, page_d;

  logic [15:0] used_full;
  logic [31:0] len_full;
  logic [33:0] rec_end;
  logic [12:0] hdr_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      used_q  <= '0;
      pos_q   <= '0;
      start_q <= '0;
      del_q   <= 1'b0;
      acc_q   <= '0;
      len_q   <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
      page_q  <= '0;
    end else if (beat_i) begin
      phase_q <= phase_d;
      used_q  <= used_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      del_q   <= del_d;
      acc_q   <= acc_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
      cnt_q   <= cnt_d;
      page_q  <= page_d;
    end
  end

  assign used_full = {data_byte_i, used_q[7:0]};
  assign len_full  = {data_byte_i, acc_q};
  assign hdr_end   = {1'b0, pos_q} + 13'(HDR_BYTES);
  assign rec_end   = 34'(start_q) + 34'(HDR_BYTES) + 34'(len_full);

  always_comb begin
    phase_d = phase_q;
    used_d  = used_q;
    pos_d   = pos_q;
    start_d = start_q;
    del_d   = del_q;
    acc_d   = acc_q;
    len_d   = len_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    page_d  = page_q;

    result_o              = '0;
    result_o.out_page     = page_q;
    result_o.row_offset   = start_q;
    result_o.row_length   = len_q;
    result_o.payload_byte = data_byte_i;

    if (first_of_page_i) begin
      page_d  = page_number_i;
      used_d  = {4'd0, data_byte_i};
      pos_d   = '0;
      start_d = '0;
      del_d   = 1'b0;
      acc_d   = '0;
      len_d   = '0;
      rem_d   = '0;
      cnt_d   = '0;
      phase_d = PH_USED_HI;
    end else begin
      case (phase_q)
        PH_USED_HI: begin
          if (used_full > 16'(DATA_BYTES)) begin
            used_d = OFFS_W'(DATA_BYTES);
          end else begin
            used_d = used_full[OFFS_W-1:0];
          end
          phase_d = PH_FLAG;
        end
        PH_FLAG: begin
          if (hdr_end > {1'b0, used_q}) begin
            phase_d = PH_DONE;
          end else begin
            start_d = pos_q;
            del_d   = data_byte_i[DELETED_BIT];
            acc_d   = '0;
            cnt_d   = '0;
            pos_d   = pos_q + 1'b1;
            phase_d = PH_LEN;
          end
        end
        PH_LEN: begin
          cnt_d = cnt_q + 1'b1;
          pos_d = pos_q + 1'b1;
          case (cnt_q)
            2'd0: acc_d[7:0]   = data_byte_i;
            2'd1: acc_d[15:8]  = data_byte_i;
            2'd2: acc_d[23:16] = data_byte_i;
            default: begin
              if (rec_end > 34'(used_q)) begin
                phase_d = PH_DONE;
              end else begin
                len_d = len_full[OFFS_W-1:0];
                if (len_full == '0) begin
                  result_o.valid        = !del_q;
                  result_o.row_length   = '0;
                  result_o.payload_byte = '0;
                  result_o.last_of_row  = 1'b1;
                  result_o.empty_row    = 1'b1;
                  phase_d               = PH_FLAG;
                end else begin
                  rem_d   = len_full[OFFS_W-1:0];
                  phase_d = PH_PAYLOAD;
                end
              end
            end
          endcase
        end
        PH_PAYLOAD: begin
          pos_d                = pos_q + 1'b1;
          rem_d                = rem_q - 1'b1;
          result_o.valid       = !del_q;
          result_o.last_of_row = (rem_q == OFFS_W'(1));
          if (rem_q == OFFS_W'(1)) begin
            phase_d = PH_FLAG;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/pre_checker.sv =====
// Checker: port-level assertions for the page record extractor, bound to the top level.
`default_nettype none
module pre_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [31:0] out_page_i,
  input wire logic [11:0] row_offset_i,
  input wire logic [11:0] row_length_i,
  input wire logic [7:0]  payload_byte_i,
  input wire logic        last_of_row_i,
  input wire logic        empty_row_i
);
  import pre_pkg::*;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_page_i) &&
      $stable(row_offset_i) && $stable(row_length_i) && $stable(payload_byte_i) &&
      $stable(last_of_row_i) && $stable(empty_row_i))
    else $error("result beat changed while stalled");

  a_beat_needs_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (!$past(out_valid_i) || $past(out_ready_i)) |->
      $past(in_valid_i && in_ready_i))
    else $error("result beat without an input beat");

  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result register");

  a_empty_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && empty_row_i |->
      last_of_row_i && payload_byte_i == 8'd0 && row_length_i == 12'd0)
    else $error("malformed empty-row beat");

  a_row_in_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      (14'(row_offset_i) + 14'(HDR_BYTES) + 14'(row_length_i)) <= 14'(DATA_BYTES))
    else $error("record runs past the data area");

endmodule

bind page_record_extractor pre_checker u_pre_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_page_i    (out_o.out_page),
  .row_offset_i  (out_o.row_offset),
  .row_length_i  (out_o.row_length),
  .payload_byte_i(out_o.payload_byte),
  .last_of_row_i (out_o.last_of_row),
  .empty_row_i   (out_o.empty_row)
);
`default_nettype wire

// ===== tb/sv/page_record_extractor_tb.sv =====
// page_record_extractor testbench: directed and random pages checked per beat against a parser model.
module page_record_extractor_tb;
  import pre_pkg::*;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_of_page;
    logic [31:0] page_number;
  } page_beat_t;

  typedef struct packed {
    logic [31:0] out_page;
    offs_t       row_offset;
    offs_t       row_length;
    logic [7:0]  payload_byte;
    logic        last_of_row;
    logic        empty_row;
  } row_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pre_in_if  in_if ();
  pre_out_if out_if ();

  page_record_extractor dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  page_beat_t  beats_to_send[$];
  row_beat_t   expected_rows[$];
  page_beat_t  next_beat;
  row_beat_t   want_row;
  row_beat_t   got_row;
  bit          byte_taken;
  int unsigned total_beats;
  int unsigned sent_count;
  int unsigned send_idle_pct;
  int unsigned take_idle_pct;
  int unsigned mismatch_count;
  int unsigned rows_checked;
  int unsigned empty_rows_checked;
  int unsigned pages_queued;

  // Parser model state
  phase_e      pg_phase;
  logic [15:0] pg_used;
  int unsigned pg_pos;
  int unsigned pg_rec_start;
  bit          pg_deleted;
  logic [31:0] pg_len;
  int unsigned pg_len_seen;
  int unsigned pg_payload_left;
  logic [31:0] pg_page;

  task automatic expect_row_beat(input logic [7:0] payload, input bit last, input bit empty);
    expected_rows.push_back('{out_page: pg_page, row_offset: offs_t'(pg_rec_start),
                              row_length: offs_t'(pg_len), payload_byte: payload,
                              last_of_row: last, empty_row: empty});
  endtask

  task automatic track_page_byte(input page_beat_t b);
    logic [63:0] row_end;
    if (b.first_of_page) begin
      pg_page         = b.page_number;
      pg_used         = {8'h00, b.data_byte};
      pg_pos          = 0;
      pg_rec_start    = 0;
      pg_deleted      = 1'b0;
      pg_len          = '0;
      pg_payload_left = 0;
      pg_len_seen     = 0;
      pg_phase        = PH_USED_HI;
      return;
    end
    case (pg_phase)
      PH_USED_HI: begin
        pg_used[15:8] = b.data_byte;
        if (pg_used > DATA_BYTES) pg_used = 16'(DATA_BYTES);
        pg_phase = PH_FLAG;
      end
      PH_FLAG: begin
        if (pg_pos + HDR_BYTES > pg_used) begin
          pg_phase = PH_DONE;
        end else begin
          pg_rec_start = pg_pos;
          pg_deleted   = b.data_byte[DELETED_BIT];
          pg_len       = '0;
          pg_len_seen  = 0;
          pg_phase     = PH_LEN;
          pg_pos++;
        end
      end
      PH_LEN: begin
        pg_len[8*pg_len_seen +: 8] = b.data_byte;
        pg_len_seen++;
        pg_pos++;
        if (pg_len_seen == 4) begin
          row_end = 64'(pg_rec_start) + 64'(HDR_BYTES) + 64'(pg_len);
          if (row_end > 64'(pg_used)) begin
            pg_phase = PH_DONE;
          end else if (pg_len == 0) begin
            if (!pg_deleted) expect_row_beat(8'h00, 1'b1, 1'b1);
            pg_phase = PH_FLAG;
          end else begin
            pg_payload_left = pg_len;
            pg_phase        = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        pg_pos++;
        pg_payload_left--;
        if (!pg_deleted) expect_row_beat(b.data_byte, pg_payload_left == 0, 1'b0);
        if (pg_payload_left == 0) pg_phase = PH_FLAG;
      end
      default: ;
    endcase
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic queue_byte(input logic [7:0] d, input bit first, input logic [31:0] pg);
    beats_to_send.push_back('{data_byte: d, first_of_page: first, page_number: pg});
    if (first) pages_queued++;
  endtask

  task automatic queue_random_page();
    logic [7:0]  area[$];
    logic [7:0]  flag;
    logic [31:0] pg;
    logic [31:0] rec_len;
    int unsigned kind;
    int unsigned used;
    int unsigned send_len;
    pg   = $urandom;
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      used = $urandom_range(0, 65535);
      repeat ($urandom_range(0, 30)) area.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        flag    = 8'($urandom_range(0, 255));
        flag[0] = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 19) == 0) rec_len = $urandom;
        else if ($urandom_range(0, 4) == 0) rec_len = 0;
        else rec_len = $urandom_range(1, 12);
        area.push_back(flag);
        for (int i = 0; i < 4; i++) area.push_back(rec_len[8*i +: 8]);
        if (rec_len <= 12) begin
          repeat (rec_len) area.push_back(8'($urandom_range(0, 255)));
        end else begin
          repeat ($urandom_range(0, 3)) area.push_back(8'($urandom_range(0, 255)));
        end
      end
      used = area.size();
      if ($urandom_range(0, 3) == 0) used += $urandom_range(1, 6);
      if (kind == 8) used = $urandom_range(0, area.size());
      if ($urandom_range(0, 9) == 0) used = $urandom_range(DATA_BYTES + 1, 65535);
    end
    send_len = (kind == 7) ? $urandom_range(0, area.size()) : area.size();
    queue_byte(used[7:0], 1'b1, pg);
    queue_byte(used[15:8], 1'b0, pg);
    for (int i = 0; i < send_len; i++) begin
      queue_byte(area[i], 1'b0, ($urandom_range(0, 15) == 0) ? $urandom : pg);
    end
    if (kind != 7) begin
      repeat ($urandom_range(0, 3)) queue_byte(8'($urandom_range(0, 255)), 1'b0, pg);
    end
  endtask

  // Input driver and output ready
  always @(negedge clk_i) begin
    if (rst_ni) begin
      case ((total_beats == 0) ? 2 : (sent_count * 3) / total_beats)
        0: begin
          send_idle_pct = 30;
          take_idle_pct = 59;
        end
        1: begin
          send_idle_pct = 59;
          take_idle_pct = 30;
        end
        default: begin
          send_idle_pct = 0;
          take_idle_pct = 0;
        end
      endcase
      if (!in_if.valid || byte_taken) begin
        if (beats_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_beat = beats_to_send.pop_front();
          in_if.valid         <= 1'b1;
          in_if.data_byte     <= next_beat.data_byte;
          in_if.first_of_page <= next_beat.first_of_page;
          in_if.page_number   <= next_beat.page_number;
          sent_count++;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= ($urandom_range(0, 99) >= take_idle_pct);
    end
  end

  // Model update and result check
  always @(posedge clk_i) begin
    byte_taken <= in_if.valid && in_if.ready;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        track_page_byte('{data_byte: in_if.data_byte, first_of_page: in_if.first_of_page,
                          page_number: in_if.page_number});
      end
      if (out_if.valid && out_if.ready) begin
        got_row = '{out_page: out_if.out_page, row_offset: out_if.row_offset,
                    row_length: out_if.row_length, payload_byte: out_if.payload_byte,
                    last_of_row: out_if.last_of_row, empty_row: out_if.empty_row};
        if (expected_rows.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got %p", $time, got_row);
          mismatch_count++;
        end else begin
          want_row = expected_rows.pop_front();
          check_field("out_page", want_row.out_page, got_row.out_page);
          check_field("row_offset", 32'(want_row.row_offset), 32'(got_row.row_offset));
          check_field("row_length", 32'(want_row.row_length), 32'(got_row.row_length));
          check_field("payload_byte", 32'(want_row.payload_byte), 32'(got_row.payload_byte));
          check_field("last_of_row", 32'(want_row.last_of_row), 32'(got_row.last_of_row));
          check_field("empty_row", 32'(want_row.empty_row), 32'(got_row.empty_row));
          rows_checked++;
          if (want_row.empty_row) empty_rows_checked++;
        end
      end
    end
  end

  initial begin
    rst_ni              = 1'b0;
    in_if.valid         = 1'b0;
    in_if.data_byte     = '0;
    in_if.first_of_page = 1'b0;
    in_if.page_number   = '0;
    out_if.ready        = 1'b0;
    pg_phase            = PH_WAIT;
    pg_used             = '0;
    pg_pos              = 0;
    pg_rec_start        = 0;
    pg_deleted          = 1'b0;
    pg_len              = '0;
    pg_len_seen         = 0;
    pg_payload_left     = 0;
    pg_page             = '0;

    // Stray byte ahead of any page
    queue_byte(8'hFF, 1'b0, 32'h1234_5678);
    // Used count 16; empty live row, deleted row, oversized length, byte past the end
    queue_byte(8'h10, 1'b1, 32'hFFFF_FFFF);
    queue_byte(8'h00, 1'b0, 32'hFFFF_FFFF);
    queue_byte(8'h00, 1'b0, 32'h0000_0000);
    repeat (4) queue_byte(8'h00, 1'b0, 32'h0000_0000);
    queue_byte(8'h01, 1'b0, 32'hFFFF_FFFF);
    queue_byte(8'h01, 1'b0, 32'hFFFF_FFFF);
    repeat (3) queue_byte(8'h00, 1'b0, 32'hFFFF_FFFF);
    queue_byte(8'hAA, 1'b0, 32'hFFFF_FFFF);
    queue_byte(8'hFE, 1'b0, 32'hFFFF_FFFF);
    repeat (4) queue_byte(8'hFF, 1'b0, 32'hFFFF_FFFF);
    queue_byte(8'h55, 1'b0, 32'hFFFF_FFFF);
    // Saturated used count; row cut short by the next page
    queue_byte(8'hFF, 1'b1, 32'h0000_0000);
    queue_byte(8'hFF, 1'b0, 32'h0000_0000);
    queue_byte(8'h00, 1'b0, 32'h0000_0000);
    queue_byte(8'h02, 1'b0, 32'h0000_0000);
    repeat (3) queue_byte(8'h00, 1'b0, 32'h0000_0000);
    queue_byte(8'h5A, 1'b0, 32'h0000_0000);

    while (beats_to_send.size() < 1230) queue_random_page();
    total_beats = beats_to_send.size();

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    do @(negedge clk_i);
    while (beats_to_send.size() != 0 || in_if.valid || expected_rows.size() != 0);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d bytes over %0d pages; checked %0d record beats, %0d of them empty rows.",
             total_beats, pages_queued, rows_checked, empty_rows_checked);
    if (mismatch_count == 0 && expected_rows.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/pre_pkg.sv
src/pre_if.sv
src/pre_parser.sv
src/page_record_extractor.sv
src/pre_checker.sv
tb/sv/page_record_extractor_tb.sv
